>>> rtl/box_downsample_two_by_two_defines.svh
// ----------------------------------------------------------------------------
// box_downsample_two_by_two_defines.svh
// Assertion macros for the downsampler RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_TWO_BY_TWO_DEFINES_SVH
`define BOX_DOWNSAMPLE_TWO_BY_TWO_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bds assertion failed");

// Next-cycle implication, disabled during reset
`define BDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bds assertion failed");

`endif

>>> rtl/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg
// Types and constants shared by the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int PIX_W   = 8;
    localparam int PAIR_W  = 9;
    localparam int SUM_W   = 10;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam int RESET_IMAGE_WIDTH  = 640;
    localparam int RESET_IMAGE_HEIGHT = 480;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_reg_idx;

    // Pair produced on one input transfer, handed to the averaging stage
    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic              use_line;  // lower row: add stored upper pair sum
        logic              last_col;
        logic              last_row;
    } t_pair_info;

endpackage

>>> rtl/bds_in_if.sv
// ----------------------------------------------------------------------------
// bds_in_if
// Input pixel channel: valid/ready handshake with one grayscale pixel.
// ----------------------------------------------------------------------------
interface bds_in_if;
    logic                      valid;
    logic                      ready;
    logic [bds_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

>>> rtl/bds_out_if.sv
// ----------------------------------------------------------------------------
// bds_out_if
// Output pixel channel: valid/ready handshake with pixel and position marks.
// ----------------------------------------------------------------------------
interface bds_out_if;
    logic                      valid;
    logic                      ready;
    logic [bds_pkg::PIX_W-1:0] pixel_out;
    logic                      row_end;
    logic                      frame_end;

    modport source (output valid, output pixel_out, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                    output ready);
endinterface

>>> rtl/bds_line_mem.sv
// ----------------------------------------------------------------------------
// bds_line_mem
// Line store of upper-row pair sums: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bds_line_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_addr,
    input  logic [bds_pkg::PAIR_W-1:0] i_wr_data,
    output logic [bds_pkg::PAIR_W-1:0] o_rd_data
);

    logic [bds_pkg::PAIR_W-1:0] r_mem [DEPTH];
    logic [bds_pkg::PAIR_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bds_scan.sv
// ----------------------------------------------------------------------------
// bds_scan
// Frame size registers, raster position counters and horizontal pairing.
// ----------------------------------------------------------------------------
module bds_scan #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int KB         = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bds_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  logic [bds_pkg::PIX_W-1:0]     i_pixel,
    output logic                          o_wr_en,
    output logic                          o_rd_en,
    output logic [KB-1:0]                 o_addr,
    output logic [bds_pkg::PAIR_W-1:0]    o_wr_data,
    output logic                          o_emit,
    output bds_pkg::t_pair_info           o_info
);

    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int RB  = $clog2(MAX_HEIGHT);
    localparam int WXW = (CB + 1 > bds_pkg::CFG_W) ? CB + 1 : bds_pkg::CFG_W;
    localparam int HXW = (RB + 1 > bds_pkg::CFG_W) ? RB + 1 : bds_pkg::CFG_W;
    localparam int RST_W = (bds_pkg::RESET_IMAGE_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : bds_pkg::RESET_IMAGE_WIDTH;
    localparam int RST_H = (bds_pkg::RESET_IMAGE_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : bds_pkg::RESET_IMAGE_HEIGHT;

    logic [CB-1:0]                r_w_m1;     // effective width minus one
    logic [RB-1:0]                r_h_m1;     // effective height minus one
    logic [CB-1:0]                r_col;
    logic [RB-1:0]                r_row;
    logic [bds_pkg::PIX_W-1:0]    r_held;

    logic [WXW-1:0]               cfg_w_ext;
    logic [HXW-1:0]               cfg_h_ext;
    logic [CB-1:0]                n_w_m1;
    logic [RB-1:0]                n_h_m1;

    logic                         col_odd;
    logic                         col_last;
    logic                         row_odd;
    logic                         row_last;
    logic                         have_pair;
    logic [bds_pkg::PAIR_W-1:0]   pair;

    // Clamp written sizes: zero acts as one, oversize acts as the maximum
    always_comb begin
        cfg_w_ext = WXW'(i_cfg_data);
        cfg_h_ext = HXW'(i_cfg_data);
        if (cfg_w_ext == '0) begin
            n_w_m1 = '0;
        end else if (cfg_w_ext > WXW'(MAX_WIDTH)) begin
            n_w_m1 = CB'(MAX_WIDTH - 1);
        end else begin
            n_w_m1 = CB'(cfg_w_ext - WXW'(1));
        end
        if (cfg_h_ext == '0) begin
            n_h_m1 = '0;
        end else if (cfg_h_ext > HXW'(MAX_HEIGHT)) begin
            n_h_m1 = RB'(MAX_HEIGHT - 1);
        end else begin
            n_h_m1 = RB'(cfg_h_ext - HXW'(1));
        end
    end

    // Pair formation and line store control
    always_comb begin
        col_odd   = r_col[0];
        col_last  = (r_col == r_w_m1);
        row_odd   = r_row[0];
        row_last  = (r_row == r_h_m1);
        have_pair = col_odd || col_last;
        if (col_odd) begin
            pair = {1'b0, r_held} + {1'b0, i_pixel};
        end else begin
            pair = {i_pixel, 1'b0};   // odd width: last pixel pairs with itself
        end
        o_addr    = KB'(r_col >> 1);
        o_wr_data = pair;
        o_wr_en   = i_accept && have_pair && !row_odd && !row_last;
        o_rd_en   = i_accept && have_pair && row_odd;
        o_emit    = i_accept && have_pair && (row_odd || row_last);
        o_info.pair     = pair;
        o_info.use_line = row_odd;
        o_info.last_col = (KB'(r_col >> 1) == KB'(r_w_m1 >> 1));
        o_info.last_row = ((r_row >> 1) == (r_h_m1 >> 1));
    end

    // Size registers, positions and held left pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1 <= CB'(RST_W - 1);
            r_h_m1 <= RB'(RST_H - 1);
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bds_pkg::REG_IMAGE_WIDTH) begin
                r_w_m1 <= n_w_m1;
                r_col  <= '0;
                r_row  <= '0;
                r_held <= '0;
            end else if (i_cfg_idx == bds_pkg::REG_IMAGE_HEIGHT) begin
                r_h_m1 <= n_h_m1;
                r_col  <= '0;
                r_row  <= '0;
                r_held <= '0;
            end
        end else if (i_accept) begin
            if (!col_odd && !col_last) begin
                r_held <= i_pixel;
            end
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + RB'(1);
            end else begin
                r_col <= r_col + CB'(1);
            end
        end
    end

endmodule

>>> rtl/bds_accum.sv
// ----------------------------------------------------------------------------
// bds_accum
// Vertical sum, averaging and output register with back-pressure.
// ----------------------------------------------------------------------------
module bds_accum (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  bds_pkg::t_pair_info        i_info,
    input  logic [bds_pkg::PAIR_W-1:0] i_rd_data,
    output logic                       o_ready,
    output logic                       o_stage_valid,
    bds_out_if.source                  o_pix_out
);

    logic                       r_s1_valid;
    bds_pkg::t_pair_info        r_s1_info;
    logic                       r_out_valid;
    logic [bds_pkg::PIX_W-1:0]  r_pixel;
    logic                       r_row_end;
    logic                       r_frame_end;

    logic                       out_free;
    logic [bds_pkg::SUM_W-1:0]  sum;

    // Output register frees up when empty or being taken
    assign out_free      = !r_out_valid || o_pix_out.ready;
    assign o_ready       = !r_s1_valid || out_free;
    assign o_stage_valid = r_s1_valid;

    // Block sum: stored upper pair plus lower pair, or last row counted twice
    always_comb begin
        if (r_s1_info.use_line) begin
            sum = {1'b0, i_rd_data} + {1'b0, r_s1_info.pair};
        end else begin
            sum = {r_s1_info.pair, 1'b0};
        end
    end

    // Control: stage and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_info <= i_info;
        end
        if (out_free && r_s1_valid) begin
            r_pixel     <= sum[bds_pkg::SUM_W-1:2];
            r_row_end   <= r_s1_info.last_col;
            r_frame_end <= r_s1_info.last_col && r_s1_info.last_row;
        end
    end

    assign o_pix_out.valid     = r_out_valid;
    assign o_pix_out.pixel_out = r_pixel;
    assign o_pix_out.row_end   = r_row_end;
    assign o_pix_out.frame_end = r_frame_end;

endmodule

>>> rtl/box_downsample_two_by_two.sv
// ----------------------------------------------------------------------------
// box_downsample_two_by_two
// Streaming 2x2 box-filter downsampler with edge replication.
//
//   Channel    Dir  Contents                        Handshake
//   i_pix_in   in   pixel_in[7:0]                   valid/ready
//   o_pix_out  out  pixel_out[7:0], row_end,        valid/ready
//                   frame_end
//   i_cfg_*    in   idx[1:0], data[10:0]            write enable only
//
// One pixel per clock while the output is not stalled; each result passes the
// line store read, then the output register, after its block's last transfer.
// Synchronous active-low reset; sizes return to 640 x 480, positions to zero.
// Line store contents are not cleared; every entry is written before use.
// A stalled output fills the sum stage, then i_pix_in.ready drops.
// ----------------------------------------------------------------------------
`include "box_downsample_two_by_two_defines.svh"

module box_downsample_two_by_two #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bds_pkg::CFG_W-1:0]     i_cfg_data,
    bds_in_if.sink                        i_pix_in,
    bds_out_if.source                     o_pix_out
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int KB = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic                        accept;
    logic                        ready;
    logic                        stage_valid;
    logic                        wr_en;
    logic                        rd_en;
    logic [KB-1:0]               addr;
    logic [bds_pkg::PAIR_W-1:0]  wr_data;
    logic [bds_pkg::PAIR_W-1:0]  rd_data;
    logic                        emit;
    bds_pkg::t_pair_info         info;

    assign i_pix_in.ready = ready;
    assign accept         = i_pix_in.valid && ready;

    // Position tracking and horizontal pairing
    bds_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .KB         (KB)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_pixel    (i_pix_in.pixel_in),
        .o_wr_en    (wr_en),
        .o_rd_en    (rd_en),
        .o_addr     (addr),
        .o_wr_data  (wr_data),
        .o_emit     (emit),
        .o_info     (info)
    );

    // Upper-row pair sums
    bds_line_mem #(
        .DEPTH (LINE_DEPTH),
        .AW    (KB)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_rd_en   (rd_en),
        .i_addr    (addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // Vertical sum and output register
    bds_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (emit),
        .i_info        (info),
        .i_rd_data     (rd_data),
        .o_ready       (ready),
        .o_stage_valid (stage_valid),
        .o_pix_out     (o_pix_out)
    );

    // Checks
    `BDS_ASSERT_NOW(a_frame_end_is_row_end, o_pix_out.valid && o_pix_out.frame_end, o_pix_out.row_end)
    `BDS_ASSERT_NEXT(a_emit_fills_stage, emit, stage_valid)
    `BDS_ASSERT_NOW(a_full_stalls_input, stage_valid && o_pix_out.valid && !o_pix_out.ready, !ready)

endmodule
